### rtl/core/bfid_pkg.sv
// Shared constants, types and channel arithmetic for the box-filter downscaler.
`timescale 1ns / 1ps
package bfid_pkg;

  localparam int MAX_OUT_WIDTH = 1024;
  localparam int COL_BITS      = $clog2(MAX_OUT_WIDTH);
  localparam int WID_BITS      = COL_BITS + 1;
  localparam int CFG_WID_BITS  = 11;
  localparam int PIX_BITS      = 8;
  localparam int CH_BITS       = 12;
  localparam int NUM_CH        = 3;
  localparam int SUM_BITS      = CH_BITS * NUM_CH;
  localparam int INV_BITS      = 16;
  localparam int FRAC_SHIFT    = 16;
  localparam int PROD_BITS     = CH_BITS + INV_BITS;
  localparam int PHASE_BITS    = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic                    SCALE_SEL_RST  = 1'b1;
  localparam logic [INV_BITS-1:0]     AREA_RECIP_RST = 16'd7282;
  localparam logic [CFG_WID_BITS-1:0] OUT_WIDTH_RST  = 11'd640;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCALE_SEL  = 2'd0,
    REG_AREA_RECIP = 2'd1,
    REG_OUT_WIDTH  = 2'd2
  } bfid_reg_t;

  // One finished horizontal block sum heading for the line store.
  typedef struct packed {
    logic [COL_BITS-1:0] addr;
    logic                row_first;
    logic                row_last;
    logic                row_end;
    logic [SUM_BITS-1:0] partial;
  } bfid_col_t;

  // Per-channel add of packed 12-bit sums, each saturating at all ones.
  function automatic logic [SUM_BITS-1:0] add_packed(input logic [SUM_BITS-1:0] a,
                                                     input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS-1:0] r;
    logic [CH_BITS:0]    s;
    r = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      s = {1'b0, a[c*CH_BITS +: CH_BITS]} + {1'b0, b[c*CH_BITS +: CH_BITS]};
      r[c*CH_BITS +: CH_BITS] = s[CH_BITS] ? {CH_BITS{1'b1}} : s[CH_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/bfid_line_store.sv
// Per-column block sum memory, registered read, write-first on collision.
`timescale 1ns / 1ps
module bfid_line_store (
  input  logic                             clk,
  input  logic                             re,
  input  logic [bfid_pkg::COL_BITS-1:0]    raddr,
  output logic [bfid_pkg::SUM_BITS-1:0]    rdata,
  input  logic                             we,
  input  logic [bfid_pkg::COL_BITS-1:0]    waddr,
  input  logic [bfid_pkg::SUM_BITS-1:0]    wdata
);
  import bfid_pkg::*;

  logic [SUM_BITS-1:0] mem [MAX_OUT_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds between reads; same-edge write to the read address is bypassed.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

### rtl/core/bfid_front.sv
// Input-side counters: column/row phase, output column and horizontal partial sum.
`timescale 1ns / 1ps
module bfid_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              frame_start,
  input  logic [bfid_pkg::PIX_BITS-1:0]     red,
  input  logic [bfid_pkg::PIX_BITS-1:0]     green,
  input  logic [bfid_pkg::PIX_BITS-1:0]     blue,
  input  logic                              scale_sel,
  input  logic [bfid_pkg::WID_BITS-1:0]     eff_width,
  output logic                              col_event,
  output bfid_pkg::bfid_col_t               col_info
);
  import bfid_pkg::*;

  logic [PHASE_BITS-1:0] col_phase, row_phase;
  logic [COL_BITS-1:0]   out_column;
  logic [SUM_BITS-1:0]   row_partial;

  logic [PHASE_BITS-1:0] cp0, rp0, last_idx;
  logic [COL_BITS-1:0]   col_raw, col0;
  logic [WID_BITS-1:0]   col_inc;
  logic                  wrap, row_last;
  logic [SUM_BITS-1:0]   pix, row_partial_next;

  always_comb begin
    cp0      = frame_start ? '0 : col_phase;
    rp0      = frame_start ? '0 : row_phase;
    col_raw  = frame_start ? '0 : out_column;
    // width lowered mid-row: restart the column count
    col0     = ({1'b0, col_raw} >= eff_width) ? '0 : col_raw;
    last_idx = scale_sel ? PHASE_BITS'(2) : PHASE_BITS'(1);
    col_event = (cp0 >= last_idx);
    row_last  = (rp0 >= last_idx);
    col_inc   = {1'b0, col0} + WID_BITS'(1);
    wrap      = (col_inc >= eff_width);
    pix = {4'b0000, blue, 4'b0000, green, 4'b0000, red};
    row_partial_next = (cp0 == '0) ? pix : add_packed(row_partial, pix);

    col_info.addr      = col0;
    col_info.row_first = (rp0 == '0);
    col_info.row_last  = row_last;
    col_info.row_end   = wrap;
    col_info.partial   = row_partial_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_phase   <= '0;
      row_phase   <= '0;
      out_column  <= '0;
      row_partial <= '0;
    end else if (accept) begin
      row_partial <= row_partial_next;
      if (col_event) begin
        col_phase  <= '0;
        out_column <= wrap ? '0 : col_inc[COL_BITS-1:0];
        if (wrap) begin
          row_phase <= row_last ? '0 : rp0 + PHASE_BITS'(1);
        end else begin
          row_phase <= rp0;
        end
      end else begin
        col_phase  <= cp0 + PHASE_BITS'(1);
        out_column <= col0;
        row_phase  <= rp0;
      end
    end
  end

  a_row_end_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && col_event && wrap |=> out_column == '0)
    else $error("column did not wrap after row end");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(out_column) && $stable(col_phase) && $stable(row_phase))
    else $error("counters moved without an accepted pixel");

endmodule

### rtl/core/bfid_average.sv
// Block average: sum register, reciprocal multiply, shift and saturate, output register.
`timescale 1ns / 1ps
module bfid_average (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [bfid_pkg::SUM_BITS-1:0]     sum,
  input  logic                              row_end,
  input  logic [bfid_pkg::INV_BITS-1:0]     area_recip,
  output logic                              ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3*bfid_pkg::PIX_BITS-1:0]   out_data,
  output logic                              out_last
);
  import bfid_pkg::*;

  logic                  va, vb;
  logic [SUM_BITS-1:0]   sum_a;
  logic                  last_a, last_b;
  logic [PROD_BITS-1:0]  prod_b [NUM_CH];
  logic                  ready_b, ready_c, go_a, go_b;
  logic [3*PIX_BITS-1:0] avg_b;

  assign ready_c = !out_valid || out_ready;
  assign ready_b = !vb || ready_c;
  assign ready   = !va || ready_b;
  assign go_a    = va && ready_b;
  assign go_b    = vb && ready_c;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      avg_b[c*PIX_BITS +: PIX_BITS] =
        (prod_b[c][PROD_BITS-1:FRAC_SHIFT] > (CH_BITS)'(255)) ? {PIX_BITS{1'b1}}
                                                               : prod_b[c][FRAC_SHIFT +: PIX_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load)      va <= 1'b1;
      else if (go_a) va <= 1'b0;
      if (go_a)      vb <= 1'b1;
      else if (go_b) vb <= 1'b0;
      if (go_b)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_a  <= sum;
      last_a <= row_end;
    end
    if (go_a) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod_b[c] <= sum_a[c*CH_BITS +: CH_BITS] * area_recip;
      end
      last_b <= last_a;
    end
    if (go_b) begin
      out_data <= avg_b;
      out_last <= last_b;
    end
  end

  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("sum stage loaded while full and stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vb && !ready_c |=> vb && $stable(last_b))
    else $error("product stage lost data under stall");

endmodule

### rtl/core/box_filter_integer_downscale.sv
// Top level of the 2x/3x box-filter RGB downscaler with stream ports and config port.
`timescale 1ns / 1ps
// A block's result passes the stage 1, sum, product and output registers before it is valid.
// Throughput: one source pixel per cycle; tready drops only when a block-closing pixel
//   finds the line-store read-modify-write stage still held by output backpressure.
// Reset (rst, synchronous): counters, pipeline valids and config registers return to
//   defaults (3x, inv 7282, width 640). The line store is not cleared; the first row
//   of a block overwrites its entries without using what was read back.
module box_filter_integer_downscale (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic                                  cfg_we,
  input  logic [bfid_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bfid_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // source pixels
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  input  logic        s_axis_tuser,   // frame_start
  // downscaled pixels
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic        m_axis_tlast    // row_end
);
  import bfid_pkg::*;

  // configuration registers
  logic                    scale_sel;
  logic [INV_BITS-1:0]     area_recip;
  logic [CFG_WID_BITS-1:0] out_width;
  logic [WID_BITS-1:0]     eff_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_sel  <= SCALE_SEL_RST;
      area_recip <= AREA_RECIP_RST;
      out_width  <= OUT_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_SEL:  scale_sel  <= cfg_data[0];
        REG_AREA_RECIP: area_recip <= cfg_data[INV_BITS-1:0];
        REG_OUT_WIDTH:  out_width  <= cfg_data[CFG_WID_BITS-1:0];
        default: ;
      endcase
    end
  end

  // width 0 behaves as 1, anything past the line store depth is clamped
  always_comb begin
    if (out_width == '0) begin
      eff_width = WID_BITS'(1);
    end else if (int'(out_width) > MAX_OUT_WIDTH) begin
      eff_width = WID_BITS'(MAX_OUT_WIDTH);
    end else begin
      eff_width = WID_BITS'(out_width);
    end
  end

  // stage 0: counters and horizontal partial sum
  logic      accept, col_event;
  bfid_col_t col_info;

  bfid_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_axis_tuser),
    .red         (s_axis_tdata[7:0]),
    .green       (s_axis_tdata[15:8]),
    .blue        (s_axis_tdata[23:16]),
    .scale_sel   (scale_sel),
    .eff_width   (eff_width),
    .col_event   (col_event),
    .col_info    (col_info)
  );

  // stage 1: line store read-modify-write. Only block-closing pixels enter it.
  logic                v1, s1_go, ready1, avg_ready, avg_load;
  bfid_col_t           s1;
  logic [SUM_BITS-1:0] rdata, sum1;

  assign s1_go         = v1 && (!s1.row_last || avg_ready);
  assign ready1        = !v1 || s1_go;
  // plain pixels never wait; a block-closing one waits for stage 1 to move
  assign s_axis_tready = !col_event || ready1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign avg_load      = s1_go && s1.row_last;

  // first block row overwrites, later rows accumulate
  assign sum1 = s1.row_first ? s1.partial : add_packed(rdata, s1.partial);

  bfid_line_store u_line_store (
    .clk   (clk),
    .re    (accept && col_event),
    .raddr (col_info.addr),
    .rdata (rdata),
    .we    (s1_go),
    .waddr (s1.addr),
    .wdata (sum1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept && col_event) begin
      v1 <= 1'b1;
    end else if (s1_go) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && col_event) begin
      s1 <= col_info;
    end
  end

  // stages 2-4: average and output register
  bfid_average u_average (
    .clk        (clk),
    .rst        (rst),
    .load       (avg_load),
    .sum        (sum1),
    .row_end    (s1.row_end),
    .area_recip (area_recip),
    .ready      (avg_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

  // a block-closing pixel is always followed by at least one in-block pixel
  a_no_back_to_back_rmw: assert property (@(posedge clk) disable iff (rst)
    accept && col_event |=> !(accept && col_event))
    else $error("two line store updates in consecutive cycles");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !s1_go |=> v1 && $stable(s1.addr) && $stable(s1.partial))
    else $error("stalled line store stage changed");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept && col_event |-> ready1)
    else $error("block-closing pixel accepted over a held stage");

endmodule

### bench/box_filter_integer_downscale_tb.sv
// Self-checking bench for the 2x/3x box-filter RGB downscaler: directed table, random phases.
`timescale 1ns / 1ps
module box_filter_integer_downscale_tb;
  import bfid_pkg::*;

  // One downscaled pixel as it leaves the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
  } out_pix_t;

  // Directed row: source pixel, plus a hand-written result where one is obvious.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
    logic       typed;
    out_pix_t   want;
  } stim_row_t;

  localparam int DIR_ROWS   = 22;
  localparam int DRAIN_WAIT = 8;   // margin after every owed beat is out
  localparam int WIDE_PIX   = 24;  // first source row only, no block closes

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_SCALE_SEL;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  logic        s_axis_tuser = 1'b0; // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  logic        m_axis_tlast;        // row_end

  box_filter_integer_downscale dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the downscaler: config copy, counters, row partial, line store.
  // ---------------------------------------------------------------------------
  logic                scale3_sh = SCALE_SEL_RST;
  logic [INV_BITS-1:0] inv_sh    = AREA_RECIP_RST;
  logic [10:0]         width_sh  = OUT_WIDTH_RST;

  logic [SUM_BITS-1:0] line_sums [MAX_OUT_WIDTH];  // left X: never read before written
  logic [SUM_BITS-1:0] hsum      = '0;
  logic [1:0]          col_phase = '0;
  logic [1:0]          row_phase = '0;
  int unsigned         out_col   = 0;

  out_pix_t    avg_q[$];        // block averages still owed by the DUT
  int          errors = 0;
  int          send_idle = 0;   // percent of cycles the source holds off
  int          recv_stall = 0;  // percent of cycles the sink backpressures
  bit          restart_frame = 1'b0;

  // Width register as the block applies it: 0 acts as 1, clamp at the store depth.
  function automatic int unsigned eff_width(input logic [10:0] w);
    if (w == 0) return 1;
    if (w > MAX_OUT_WIDTH) return MAX_OUT_WIDTH;
    return 32'(w);
  endfunction

  // Per-channel add of three packed 12-bit sums, saturating each at all ones.
  function automatic logic [SUM_BITS-1:0] chan_add(input logic [SUM_BITS-1:0] a,
                                                   input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS-1:0] r;
    logic [CH_BITS:0]    s;
    for (int c = 0; c < NUM_CH; c++) begin
      s = a[c*CH_BITS +: CH_BITS] + b[c*CH_BITS +: CH_BITS];
      r[c*CH_BITS +: CH_BITS] = s[CH_BITS] ? {CH_BITS{1'b1}} : s[CH_BITS-1:0];
    end
    return r;
  endfunction

  // Block sum times reciprocal, drop 16 fraction bits, clip to 8 bits.
  function automatic logic [7:0] block_avg(input logic [CH_BITS-1:0] s);
    logic [PROD_BITS-1:0] prod;
    prod = s * inv_sh;
    prod = prod >> FRAC_SHIFT;
    return (prod > 255) ? 8'hFF : prod[7:0];
  endfunction

  // Advance the shadow by one accepted source pixel; 1 when a block closes.
  function automatic bit box_step(input logic [23:0] px, input logic fs,
                                  output out_pix_t res);
    int unsigned         scale;
    int unsigned         w;
    logic [SUM_BITS-1:0] pk;
    bit                  done;
    scale = scale3_sh ? 3 : 2;
    w     = eff_width(width_sh);
    done  = 1'b0;
    res   = '0;
    if (fs) begin
      col_phase = '0;
      row_phase = '0;
      out_col   = 0;
      hsum      = '0;
    end
    // width lowered mid-row: restart the column count
    if (out_col >= w) out_col = 0;
    pk   = {4'b0, px[23:16], 4'b0, px[15:8], 4'b0, px[7:0]};
    hsum = (col_phase == 0) ? pk : chan_add(hsum, pk);
    // a phase left past the scale (mode changed mid-block) closes the block
    if (col_phase + 1 < scale) begin
      col_phase = col_phase + 2'd1;
      return 1'b0;
    end
    col_phase = '0;
    line_sums[out_col] = (row_phase == 0) ? hsum : chan_add(line_sums[out_col], hsum);
    if (row_phase + 1 >= scale) begin
      res.red     = block_avg(line_sums[out_col][11:0]);
      res.green   = block_avg(line_sums[out_col][23:12]);
      res.blue    = block_avg(line_sums[out_col][35:24]);
      res.row_end = (out_col + 1 >= w);
      done = 1'b1;
    end
    out_col++;
    if (out_col >= w) begin
      out_col   = 0;
      row_phase = (row_phase + 1 >= scale) ? 2'd0 : row_phase + 2'd1;
    end
    return done;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Write all three registers back to back, then mirror them in the shadow.
  task automatic cfg_apply(input logic sm, input logic [15:0] inv, input logic [10:0] w);
    int unsigned prev_w;
    prev_w = eff_width(width_sh);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCALE_SEL;
    cfg_data  <= {15'b0, sm};
    @(negedge clk);
    cfg_index <= REG_AREA_RECIP;
    cfg_data  <= inv;
    @(negedge clk);
    cfg_index <= REG_OUT_WIDTH;
    cfg_data  <= {5'b0, w};
    @(negedge clk);
    cfg_we    <= 1'b0;
    scale3_sh = sm;
    inv_sh    = inv;
    width_sh  = w;
    // a wider row could hit line-store columns never written: open a new frame
    if (eff_width(w) > prev_w) restart_frame = 1'b1;
  endtask

  // Offer one source beat, hold it until taken, then book its result.
  task automatic send_px(input logic [23:0] px, input logic fs,
                         input bit typed, input out_pix_t want);
    out_pix_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= fs;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (box_step(px, fs, res)) avg_q.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Stop the source and let every owed beat come out, plus the pipeline depth.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (avg_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 53; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 53; end
      default: begin send_idle = 13; recv_stall = 13; end
    endcase
  endtask

  // Channel value with extra weight on the rails.
  function automatic logic [7:0] chan_val();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sink backpressure, redrawn every cycle.
  always @(negedge clk) m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);

  // ---------------------------------------------------------------------------
  // Checking: each output beat against the oldest owed average.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_pix_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (avg_q.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing owed, expected none actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = avg_q.pop_front();
        check_field("red_out",   want.red,   m_axis_tdata[7:0]);
        check_field("green_out", want.green, m_axis_tdata[15:8]);
        check_field("blue_out",  want.blue,  m_axis_tdata[23:16]);
        check_field("row_end",   {7'b0, want.row_end}, {7'b0, m_axis_tlast});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table, run at 2x, reciprocal 1/4, one output pixel per row, so each
  // four beats close one block and every result is a row end.
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab [DIR_ROWS] = '{
    // all ones saturate nothing: average is 255 exactly
    '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
    // all zeros
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
    // alternating bit patterns, one per channel
    '{8'hAA, 8'h55, 8'h0F, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'hAA, 8'h55, 8'h0F, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'hAA, 8'h55, 8'h0F, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'hAA, 8'h55, 8'h0F, 1'b0, 1'b1, '{8'hAA, 8'h55, 8'h0F, 1'b1}},
    // frame start mid-block throws away the half-built block
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'h04, 8'h04, 8'h04, 1'b1, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'h04, 8'h04, 8'h04, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'h04, 8'h04, 8'h04, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'h04, 8'h04, 8'h04, 1'b0, 1'b1, '{8'h04, 8'h04, 8'h04, 1'b1}},
    // uneven values, truncating division: left to the shadow
    '{8'd10, 8'd200, 8'd7,   1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'd20, 8'd100, 8'd8,   1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'd30, 8'd50,  8'd9,   1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{8'd41, 8'd25,  8'd250, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}}
  };

  initial begin
    int          ph;
    int          n;
    logic        sm;
    logic [15:0] inv;
    logic [10:0] w;
    logic        fs;
    logic        open_frame;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // --- directed part -------------------------------------------------------
    cfg_apply(1'b0, 16'd16384, 11'd1);
    foreach (dir_tab[i])
      send_px({dir_tab[i].blue, dir_tab[i].green, dir_tab[i].red},
              dir_tab[i].frame_start, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // --- random phases -------------------------------------------------------
    // Scale alternates so mode changes land mid-block both ways; widths stay
    // small so rows wrap often. Phases that draw no new frame carry on the old
    // frame, which walks into the width-shrink and phase-past-scale cases.
    for (ph = 0; ph < 12; ph++) begin
      set_idle(ph % 4);
      sm = ph[0];
      case (ph)
        2:       inv = 16'd0;
        5:       inv = 16'hFFFF;                     // blocks summing past 256 saturate
        default: inv = $urandom_range(0, 1) ? (sm ? 16'd7282 : 16'd16384)
                                            : 16'($urandom_range(0, 65535));
      endcase
      case (ph)
        3:       w = 11'd0;                          // acts as one pixel
        7:       w = 11'd1;
        default: w = 11'($urandom_range(1, 6));
      endcase
      cfg_apply(sm, inv, w);

      n = $urandom_range(35, 50);
      open_frame = 1'($urandom_range(0, 1));
      for (int k = 0; k < n; k++) begin
        // pressure point: source holds until every owed beat is out
        if (ph == 6 && k == n / 2) drain();
        fs = restart_frame || (k == 0 && open_frame) || ($urandom_range(0, 39) == 0);
        restart_frame = 1'b0;
        send_px({chan_val(), chan_val(), chan_val()}, fs, 1'b0, '0);
      end
      drain();
    end

    // --- short pass with the width register all ones: clamps to the store depth
    set_idle(0);
    cfg_apply(1'b0, 16'd16384, 11'h7FF);
    for (int k = 0; k < WIDE_PIX; k++) begin
      fs = restart_frame;
      restart_frame = 1'b0;
      send_px({chan_val(), chan_val(), chan_val()}, fs, 1'b0, '0);
    end

    drain();
    if (errors == 0)
      $display("box_filter_integer_downscale verification clean");
    else
      $display("box_filter_integer_downscale verification failed");
    $finish;
  end

  // Watchdog: ends a run that never finishes.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d beats still owed", $time, avg_q.size());
    $display("box_filter_integer_downscale verification failed");
    $finish;
  end

endmodule
